// ===== sv/fas_pkg.sv =====
`default_nettype none
package fas_pkg;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_PLAY    = 3'd1,
		OP_PAUSE   = 3'd2,
		OP_RESTART = 3'd3,
		OP_SET     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MODE_PLAYING  = 2'd0,
		MODE_PAUSED   = 2'd1,
		MODE_COOLDOWN = 2'd2,
		MODE_ENDED    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_DIV,
		SEQ_FIN
	} seq_state_t;

	typedef enum logic [1:0] {
		REG_FRAME_TOTAL = 2'd0,
		REG_INTERVAL    = 2'd1,
		REG_LOOP        = 2'd2,
		REG_COOLDOWN    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	localparam int DIVIDEND_W = 32;
	localparam int DIVISOR_W  = 16;

endpackage
`default_nettype wire

// ===== sv/fas_div.sv =====
`default_nettype none
module fas_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [fas_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [fas_pkg::DIVISOR_W-1:0]  divisor,
	output fas_pkg::div_stat_t                  stat,
	output logic [fas_pkg::DIVIDEND_W-1:0]      quotient
);
	import fas_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic                  ge;
	logic [DIVISOR_W:0]    diff;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire

// ===== sv/frame_animation_sequencer.sv =====
`default_nettype none
// Frame animation sequencer.
// Input stream (s_*): one event per transfer - tick, play, pause, restart or
// set frame. Output stream (m_*): one transfer per event carrying the frame
// index and play state after that event.
// Configuration is written through cfg_we/cfg_index/cfg_data: frame count,
// frame interval, loop enable and cooldown length; the user must write it only
// while idle, as the block does not enforce this. Every event other than a tick
// while playing gives its result on the cycle after its transfer. A tick while
// playing runs a 32-bit restoring division of the accumulated time by the
// interval, one quotient bit per cycle, and gives its result after the divide
// and finish states. Throughput: one event per cycle at best while the receiver
// keeps up; the shared divider holds off new events during a tick while playing.
// The block takes a new event only while the sequencer is idle and the
// output register is empty or being emptied in the same cycle; a stalled
// receiver therefore holds the result and back-pressures the input.
// Reset leaves the block paused at frame 0 with the accumulator cleared,
// one frame, a 41 ms interval, looping off and no cooldown.
module frame_animation_sequencer #(
	parameter int MAX_FRAMES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// operation[2:0], delta_ms[18:3], now_ms[50:19], target_frame[62:51]
	input  wire logic [63:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// frame_index[11:0], play_state[13:12]
	output logic [15:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import fas_pkg::*;

	localparam int CAP_I = (MAX_FRAMES < 4096) ? MAX_FRAMES : 4096;
	localparam logic [12:0] TOT_CAP = 13'(CAP_I);

	logic [12:0] frame_total_q;
	logic [15:0] interval_q;
	logic        loop_q;
	logic [15:0] cooldown_q;

	mode_t       mode_q, mode_d;
	logic [11:0] cur_q, cur_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] cend_q, cend_d;
	logic        fws_q, fws_d;
	logic [31:0] now_q;
	seq_state_t  seq_q, seq_d;

	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;

	logic        s_accept;
	logic        out_load;
	logic        div_start;
	div_stat_t   div_stat;
	logic [31:0] quotient;

	logic [2:0]  in_op;
	logic [15:0] in_delta;
	logic [31:0] in_now;
	logic [11:0] in_target;

	logic [12:0] total;
	logic [11:0] last;
	logic [32:0] sum33;
	logic [31:0] sum_sat;
	logic [15:0] ivl;
	logic [32:0] idx33;

	assign in_op     = s_tdata[2:0];
	assign in_delta  = s_tdata[18:3];
	assign in_now    = s_tdata[50:19];
	assign in_target = s_tdata[62:51];

	assign s_tready = (seq_q == SEQ_IDLE) && (!m_tvalid_q || m_tready);
	assign s_accept = s_tvalid && s_tready;

	always_comb begin
		if (frame_total_q == 13'd0)
			total = 13'd1;
		else if (frame_total_q > TOT_CAP)
			total = TOT_CAP;
		else
			total = frame_total_q;
		last    = 12'(total - 13'd1);
		sum33   = {1'b0, acc_q} + {17'd0, in_delta};
		sum_sat = sum33[32] ? '1 : sum33[31:0];
		ivl     = (interval_q == 16'd0) ? 16'd1 : interval_q;
		idx33   = {21'd0, cur_q} + {1'b0, quotient};
	end

	fas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_sat),
		.divisor  (ivl),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_comb begin
		mode_d    = mode_q;
		cur_d     = cur_q;
		acc_d     = acc_q;
		cend_d    = cend_q;
		fws_d     = fws_q;
		seq_d     = seq_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (seq_q)
			SEQ_IDLE: begin
				if (s_accept) begin
					out_load = 1'b1;
					case (in_op)
						OP_TICK: begin
							if (mode_q == MODE_PLAYING) begin
								acc_d     = sum_sat;
								div_start = 1'b1;
								out_load  = 1'b0;
								seq_d     = SEQ_DIV;
							end else if (mode_q == MODE_COOLDOWN && in_now >= cend_q) begin
								if (!fws_q)
									cur_d = '0;
								fws_d  = 1'b0;
								mode_d = MODE_PLAYING;
							end
						end
						OP_PLAY: begin
							if (mode_q == MODE_ENDED || mode_q == MODE_COOLDOWN) begin
								if (!fws_q)
									cur_d = '0;
								fws_d = 1'b0;
							end
							mode_d = MODE_PLAYING;
						end
						OP_PAUSE: begin
							if (mode_q == MODE_PLAYING || mode_q == MODE_COOLDOWN)
								mode_d = MODE_PAUSED;
						end
						OP_RESTART: begin
							cur_d  = '0;
							acc_d  = '0;
							cend_d = '0;
							fws_d  = 1'b0;
							mode_d = MODE_PLAYING;
						end
						OP_SET: begin
							cur_d = (in_target < last) ? in_target : last;
							if (mode_q == MODE_ENDED || mode_q == MODE_COOLDOWN)
								fws_d = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			SEQ_DIV: begin
				if (div_stat.done)
					seq_d = SEQ_FIN;
			end
			SEQ_FIN: begin
				out_load = 1'b1;
				seq_d    = SEQ_IDLE;
				// advance only when a whole frame is due; drop the remainder
				if (quotient != 32'd0) begin
					acc_d = '0;
					if (idx33 >= {20'd0, total}) begin
						cur_d = last;
						if (loop_q) begin
							cend_d = now_q + {16'd0, cooldown_q};
							mode_d = MODE_COOLDOWN;
						end else begin
							mode_d = MODE_ENDED;
						end
					end else begin
						cur_d = idx33[11:0];
					end
				end
			end
			default: seq_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_total_q <= 13'd1;
			interval_q    <= 16'd41;
			loop_q        <= 1'b0;
			cooldown_q    <= '0;
			mode_q        <= MODE_PAUSED;
			cur_q         <= '0;
			acc_q         <= '0;
			cend_q        <= '0;
			fws_q         <= 1'b0;
			seq_q         <= SEQ_IDLE;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_TOTAL: frame_total_q <= cfg_data[12:0] | 13'd0;
					REG_INTERVAL:    interval_q    <= cfg_data;
					REG_LOOP:        loop_q        <= cfg_data[0];
					REG_COOLDOWN:    cooldown_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			mode_q <= mode_d;
			cur_q  <= cur_d;
			acc_q  <= acc_d;
			cend_q <= cend_d;
			fws_q  <= fws_d;
			seq_q  <= seq_d;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start)
			now_q <= in_now;
		if (out_load)
			m_tdata_q <= {2'b00, mode_d, cur_d};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// ===== tb/frame_animation_sequencer_tb.sv =====
`timescale 1ns / 100ps
module frame_animation_sequencer_tb;
	import fas_pkg::*;

	localparam int FRAME_LIMIT = 4096;
	localparam logic [2:0] OP_CODE_MAX = 3'd7;
	localparam int REPORT_LIMIT = 10;
	localparam int PHASE_ITEMS = 120;

	typedef struct packed {
		logic [11:0] target_frame;
		logic [31:0] now_ms;
		logic [15:0] delta_ms;
		logic [2:0]  operation;
	} event_t;

	typedef struct {
		logic [11:0] frame_index;
		mode_t       play_state;
	} view_t;

	class frame_seq_scoreboard;
		logic [12:0] frame_total;
		logic [15:0] interval_ms;
		logic        loop_enable;
		logic [15:0] cooldown_ms;
		mode_t       mode;
		logic [11:0] frame;
		logic [31:0] accum;
		logic [31:0] cooldown_end;
		logic        frame_was_set;
		view_t       awaited[$];
		int          mismatches;

		function new();
			frame_total = 13'd1;
			interval_ms = 16'd41;
			loop_enable = 1'b0;
			cooldown_ms = 16'd0;
			mode = MODE_PAUSED;
			frame = '0;
			accum = '0;
			cooldown_end = '0;
			frame_was_set = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] value);
			case (idx)
				REG_FRAME_TOTAL: frame_total = value[12:0];
				REG_INTERVAL:    interval_ms = value;
				REG_LOOP:        loop_enable = value[0];
				REG_COOLDOWN:    cooldown_ms = value;
				default: ;
			endcase
		endfunction

		function int unsigned frame_count();
			int unsigned n;
			n = {19'd0, frame_total};
			if (n > FRAME_LIMIT) n = FRAME_LIMIT;
			if (n == 0) n = 1;
			return n;
		endfunction

		function void resume();
			if (mode == MODE_PLAYING) return;
			if (mode == MODE_ENDED || mode == MODE_COOLDOWN) begin
				if (!frame_was_set) frame = '0;
				frame_was_set = 1'b0;
			end
			mode = MODE_PLAYING;
		endfunction

		function void advance(logic [15:0] delta, logic [31:0] now);
			longint unsigned sum;
			longint unsigned divisor;
			longint unsigned due;
			longint unsigned idx;
			int unsigned count;
			if (mode == MODE_PAUSED || mode == MODE_ENDED) return;
			if (mode == MODE_COOLDOWN) begin
				if (now >= cooldown_end) resume();
				return;
			end
			sum = {32'd0, accum};
			sum += {48'd0, delta};
			if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
			accum = sum[31:0];
			divisor = (interval_ms == 16'd0) ? 64'd1 : {48'd0, interval_ms};
			due = sum / divisor;
			if (due == 0) return;
			idx = {52'd0, frame};
			idx += due;
			if (idx > 64'hFFFF_FFFF) idx = 64'hFFFF_FFFF;
			accum = '0;
			count = frame_count();
			if (idx >= count) begin
				if (loop_enable) begin
					// end time wraps at 32 bits
					cooldown_end = now + {16'd0, cooldown_ms};
					mode = MODE_COOLDOWN;
				end else begin
					mode = MODE_ENDED;
				end
				idx = {32'd0, count - 32'd1};
			end
			frame = idx[11:0];
		endfunction

		function void note_event(event_t ev);
			int unsigned last;
			view_t v;
			case (ev.operation)
				OP_TICK:  advance(ev.delta_ms, ev.now_ms);
				OP_PLAY:  resume();
				OP_PAUSE: begin
					if (mode == MODE_PLAYING || mode == MODE_COOLDOWN) mode = MODE_PAUSED;
				end
				OP_RESTART: begin
					frame = '0;
					accum = '0;
					cooldown_end = '0;
					frame_was_set = 1'b0;
					mode = MODE_PLAYING;
				end
				OP_SET: begin
					last = frame_count() - 1;
					frame = (ev.target_frame < last) ? ev.target_frame : last[11:0];
					if (mode == MODE_ENDED || mode == MODE_COOLDOWN) frame_was_set = 1'b1;
				end
				default: ;
			endcase
			v.frame_index = frame;
			v.play_state = mode;
			awaited.insert(awaited.size(), v);
		endfunction

		function void check_result(logic [15:0] data);
			view_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: frame %0d state %0d", data[11:0], data[13:12]);
				return;
			end
			want = awaited.pop_front();
			if (data[11:0] !== want.frame_index || data[13:12] !== want.play_state) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result mismatch: expected frame %0d state %0d, got frame %0d state %0d",
						want.frame_index, want.play_state, data[11:0], data[13:12]);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	frame_seq_scoreboard sb;
	logic        idle_on;
	logic        stall_on;
	int          stall_left;
	logic [31:0] time_base;
	logic [15:0] cur_interval;
	logic [12:0] cur_total;

	frame_animation_sequencer #(
		.MAX_FRAMES(FRAME_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: random stalls, mostly short
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!stall_on || $urandom_range(0, 99) < 65) begin
			m_tready <= 1'b1;
		end else begin
			stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 50);
			m_tready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	function automatic int idle_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	function automatic event_t make_event(logic [2:0] op, logic [15:0] delta,
			logic [31:0] now, logic [11:0] target);
		event_t ev;
		ev.operation = op;
		ev.delta_ms = delta;
		ev.now_ms = now;
		ev.target_frame = target;
		return ev;
	endfunction

	function automatic event_t random_event();
		event_t ev;
		int r;
		int unsigned span;
		r = $urandom_range(0, 99);
		if (r < 55)      ev.operation = OP_TICK;
		else if (r < 67) ev.operation = OP_PLAY;
		else if (r < 73) ev.operation = OP_PAUSE;
		else if (r < 79) ev.operation = OP_RESTART;
		else if (r < 95) ev.operation = OP_SET;
		else             ev.operation = 3'($urandom_range(int'(OP_SET) + 1, OP_CODE_MAX));
		// keep most deltas near a few frame intervals so the index moves steadily
		span = (cur_interval == 16'd0) ? 4 : 4 * cur_interval;
		if (span > 65535) span = 65535;
		ev.delta_ms = 16'(($urandom_range(0, 9) < 7) ? $urandom_range(0, span) : $urandom);
		if ($urandom_range(0, 3) == 0) time_base += $urandom_range(0, 70000);
		else time_base += {16'd0, ev.delta_ms};
		if ($urandom_range(0, 29) == 0) time_base = $urandom;
		ev.now_ms = time_base;
		if ($urandom_range(0, 1) == 0) ev.target_frame = 12'($urandom);
		else if (cur_total > 13'd4094) ev.target_frame = 12'($urandom);
		else ev.target_frame = 12'($urandom_range(0, cur_total + 1));
		return ev;
	endfunction

	task automatic write_cfg(reg_idx_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
		if (idx == REG_INTERVAL) cur_interval = value;
		if (idx == REG_FRAME_TOTAL) cur_total = value[12:0];
	endtask

	task automatic configure(logic [12:0] total, logic [15:0] interval, logic loop_en,
			logic [15:0] cooldown);
		write_cfg(REG_FRAME_TOTAL, {3'd0, total});
		write_cfg(REG_INTERVAL, interval);
		write_cfg(REG_LOOP, {15'd0, loop_en});
		write_cfg(REG_COOLDOWN, cooldown);
		cfg_we <= 1'b0;
	endtask

	task automatic send_event(event_t ev);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, ev};
		do @(posedge clk); while (!s_tready);
		sb.note_event(ev);
	endtask

	// drop valid and hold until every expected result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(logic [12:0] total, logic [15:0] interval, logic loop_en,
			logic [15:0] cooldown, logic busy_sides);
		configure(total, interval, loop_en, cooldown);
		idle_on = busy_sides;
		stall_on = busy_sides;
		repeat (PHASE_ITEMS) send_event(random_event());
		drain();
	endtask

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int fails;
		logic [2:0] code;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		stall_left = 0;
		time_base = $urandom;
		cur_interval = 16'd41;
		cur_total = 13'd1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: eight frames, zero interval, looping with the longest cooldown
		configure(13'd8, 16'd0, 1'b1, 16'hFFFF);
		send_event(make_event(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 12'd0));
		send_event(make_event(OP_SET, 16'd0, 32'd0, 12'hFFF));
		send_event(make_event(OP_PLAY, 16'd0, 32'd0, 12'd0));
		send_event(make_event(OP_PLAY, 16'd0, 32'd0, 12'd0));
		send_event(make_event(OP_TICK, 16'd0, 32'd0, 12'd0));
		// passes the end near the top of time: cooldown end wraps
		send_event(make_event(OP_TICK, 16'd1, 32'hFFFF_FFF0, 12'd0));
		send_event(make_event(OP_TICK, 16'd0, 32'h0000_1000, 12'd0));
		send_event(make_event(OP_SET, 16'd0, 32'd0, 12'd3));
		send_event(make_event(OP_TICK, 16'd0, 32'h0000_FFEF, 12'd0));
		send_event(make_event(OP_TICK, 16'hFFFF, 32'd5, 12'd0));
		send_event(make_event(OP_PAUSE, 16'd0, 32'd0, 12'd0));
		send_event(make_event(OP_PLAY, 16'd0, 32'd0, 12'd0));
		send_event(make_event(OP_RESTART, 16'd0, 32'd0, 12'd0));
		for (code = OP_SET + 3'd1; code != 3'd0; code = code + 3'd1)
			send_event(make_event(code, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF));
		drain();

		write_cfg(REG_LOOP, 16'd0);
		cfg_we <= 1'b0;
		send_event(make_event(OP_TICK, 16'hFFFF, 32'd100, 12'd0));
		send_event(make_event(OP_TICK, 16'hFFFF, 32'd200, 12'd0));
		send_event(make_event(OP_PAUSE, 16'd0, 32'd0, 12'd0));
		send_event(make_event(OP_SET, 16'd0, 32'd0, 12'd2));
		send_event(make_event(OP_PLAY, 16'd0, 32'd0, 12'd0));
		send_event(make_event(OP_TICK, 16'd9, 32'd300, 12'd0));
		send_event(make_event(OP_PLAY, 16'd0, 32'd0, 12'd0));
		drain();

		run_phase(13'd1, 16'd0, 1'b0, 16'd0, 1'b0);
		run_phase(13'd4096, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
		run_phase(13'd8, 16'd3, 1'b1, 16'd50, 1'b1);
		run_phase(13'd4096, 16'd0, 1'b1, 16'd0, 1'b1);
		run_phase(13'd2, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1);
		repeat (5) begin
			run_phase(
				13'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 16) : $urandom_range(1, 4096)),
				16'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 200) : $urandom_range(0, 65535)),
				1'($urandom_range(0, 1)),
				16'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 300) : $urandom_range(0, 65535)),
				$urandom_range(0, 4) != 0);
		end

		repeat (40) @(posedge clk);
		fails = sb.mismatches + sb.awaited.size();
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
sv/fas_pkg.sv
sv/fas_div.sv
sv/frame_animation_sequencer.sv
tb/frame_animation_sequencer_tb.sv
